>>> rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants for the k-core decomposition block
// Command and result transaction layouts, adder request and response, status and opcode codes, sizes.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int unsigned VW  = 10;           // vertex id width
    localparam int unsigned CW  = 11;           // vertex count width
    localparam int unsigned EW  = 13;           // edge count width
    localparam int unsigned EAW = 12;           // edge store address
    localparam int unsigned OW  = 14;           // adjacency offset width
    localparam int unsigned OAW = 11;           // offset store address
    localparam int unsigned AAW = 13;           // adjacency list address
    localparam int unsigned BW  = 11;           // bucket start width

    localparam logic [CW-1:0] NUM_VERTICES = 11'd1024;
    localparam logic [VW-1:0] MAX_DEGREE   = 10'd1023;
    localparam logic [EW-1:0] NUM_EDGES    = 13'd4096;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]    opcode;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_cmd;

    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] core_number;
        logic [VW-1:0] vertex_id;
    } t_res;

    typedef struct packed {
        logic [OW-1:0] a;
        logic [OW-1:0] b;
        logic          sub;
    } t_alu_req;

    typedef struct packed {
        logic [OW-1:0] sum;
        logic          gt;
    } t_alu_rsp;

endpackage

>>> rtl/core/graph_core_decomposition.sv
// ----------------------------------------------------------------------------
// graph_core_decomposition: k-core decomposition by bucket-sorted peeling
// Edge store, degree tracking, run sequencer and core-number readback.
// ----------------------------------------------------------------------------
// One command transaction is taken when start is high and busy is low; each
// command gives exactly one result, shown for one cycle with o_valid high,
// and the receiver cannot stall it. Adds rejected on acceptance, rejected
// reads, unused opcodes and invalid reads answer the cycle after acceptance;
// an accepted add does two degree read-modify-writes on the degree store,
// which has one write port. A run is a long sequence on one shared adder
// and the work memories: clear, count, offsets, adjacency, bucket sums,
// sort, bucket shift and peel. After reset a sweep over all 1024 entries
// clears the degree store; busy is high throughout. vertex_count is written
// over the APB port, at the addresses with paddr[2] low (0 to 3).
// ----------------------------------------------------------------------------
module graph_core_decomposition (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  gcd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output gcd_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int unsigned VW  = gcd_pkg::VW;
    localparam int unsigned CW  = gcd_pkg::CW;
    localparam int unsigned EW  = gcd_pkg::EW;
    localparam int unsigned EAW = gcd_pkg::EAW;
    localparam int unsigned OW  = gcd_pkg::OW;
    localparam int unsigned OAW = gcd_pkg::OAW;
    localparam int unsigned AAW = gcd_pkg::AAW;
    localparam int unsigned BW  = gcd_pkg::BW;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_ADD1, S_ADD2, S_ADD3, S_READ,
        S_CLR, S_CNT0, S_CNT1, S_CNT2, S_CNT3,
        S_OFS0, S_OFS1, S_OFS2, S_OFSN,
        S_ADJ0, S_ADJ1, S_ADJ2, S_ADJ3,
        S_PFX0, S_PFX1, S_SRT0, S_SRT1, S_SRT2,
        S_SHF0, S_SHF1, S_SHF2,
        S_K0, S_K1, S_K2, S_K3, S_K4,
        S_J0, S_J1, S_J2, S_J3, S_J4, S_J5, S_J6
    } t_state;

    t_state r_state;

    // control and datapath registers
    logic [CW-1:0]  r_vcount;
    logic [EW-1:0]  r_etot;
    logic           r_rv;          // core numbers valid
    logic           r_out_valid;
    gcd_pkg::t_res  r_res;
    logic [VW-1:0]  r_clr;
    logic [VW-1:0]  r_a, r_b, r_da;
    logic [EW-1:0]  r_e;
    logic [VW-1:0]  r_ea, r_eb;
    logic [VW-1:0]  r_md;
    logic [CW-1:0]  r_v;
    logic [OW-1:0]  r_run;
    logic [VW-1:0]  r_dd;
    logic [VW-1:0]  r_d;
    logic [CW-1:0]  r_i;
    logic [OW-1:0]  r_j, r_jend;
    logic [VW-1:0]  r_dv, r_u, r_du, r_pu, r_pw, r_w;
    logic [BW-1:0]  r_pw1;

    // live vertex count, clamped to 1 .. 1024
    logic [CW-1:0] n_cnt;
    always_comb begin
        if (r_vcount == '0) begin
            n_cnt = CW'(1);
        end else if (r_vcount > gcd_pkg::NUM_VERTICES) begin
            n_cnt = gcd_pkg::NUM_VERTICES;
        end else begin
            n_cnt = r_vcount;
        end
    end

    // memory ports
    logic               edge_we;
    logic [EAW-1:0]     edge_waddr, edge_raddr;
    logic [2*VW-1:0]    edge_wdata, edge_rd;
    logic               dfull_we;
    logic [VW-1:0]      dfull_waddr, dfull_raddr, dfull_wdata, dfull_rd;
    logic               deg_we;
    logic [VW-1:0]      deg_waddr, deg_raddr, deg_wdata, deg_rd;
    logic               offs_we;
    logic [OAW-1:0]     offs_waddr, offs_raddr;
    logic [OW-1:0]      offs_wdata, offs_rd;
    logic               adj_we;
    logic [AAW-1:0]     adj_waddr, adj_raddr;
    logic [VW-1:0]      adj_wdata, adj_rd;
    logic               bst_we;
    logic [VW-1:0]      bst_waddr, bst_raddr;
    logic [BW-1:0]      bst_wdata, bst_rd;
    logic               pos_we;
    logic [VW-1:0]      pos_waddr, pos_raddr, pos_wdata, pos_rd;
    logic               vert_we;
    logic [VW-1:0]      vert_waddr, vert_raddr, vert_wdata, vert_rd;

    gcd_pkg::t_alu_req alu_req;
    gcd_pkg::t_alu_rsp alu_rsp;

    // edge endpoints as read back from the store
    logic [VW-1:0] e_a, e_b;
    logic          e_in;
    assign e_a  = edge_rd[2*VW-1:VW];
    assign e_b  = edge_rd[VW-1:0];
    assign e_in = ({1'b0, e_a} < n_cnt) && ({1'b0, e_b} < n_cnt);

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    gcd_alu u_alu (.i_req(alu_req), .o_rsp(alu_rsp));

    gcd_ram #(.W(2*VW), .D(4096)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rd));
    gcd_ram #(.W(VW), .D(1024)) u_dfull (
        .i_clk(i_clk), .i_we(dfull_we), .i_waddr(dfull_waddr), .i_wdata(dfull_wdata),
        .i_raddr(dfull_raddr), .o_rdata(dfull_rd));
    gcd_ram #(.W(VW), .D(1024)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_rd));
    gcd_ram #(.W(OW), .D(1025)) u_offs (
        .i_clk(i_clk), .i_we(offs_we), .i_waddr(offs_waddr), .i_wdata(offs_wdata),
        .i_raddr(offs_raddr), .o_rdata(offs_rd));
    gcd_ram #(.W(VW), .D(8192)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rd));
    gcd_ram #(.W(BW), .D(1024)) u_bst (
        .i_clk(i_clk), .i_we(bst_we), .i_waddr(bst_waddr), .i_wdata(bst_wdata),
        .i_raddr(bst_raddr), .o_rdata(bst_rd));
    gcd_ram #(.W(VW), .D(1024)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rd));
    gcd_ram #(.W(VW), .D(1024)) u_vert (
        .i_clk(i_clk), .i_we(vert_we), .i_waddr(vert_waddr), .i_wdata(vert_wdata),
        .i_raddr(vert_raddr), .o_rdata(vert_rd));

    // shared adder operands per step
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_ADD2: begin
                alu_req.a = OW'(dfull_rd);
                alu_req.b = OW'(1);
            end
            S_ADD3: begin
                alu_req.a = OW'(r_da);
                alu_req.b = OW'(1);
            end
            S_CNT2, S_CNT3: begin
                alu_req.a = OW'(deg_rd);
                alu_req.b = OW'(1);
            end
            S_OFS1: begin
                alu_req.a = r_run;
                alu_req.b = OW'(deg_rd);
            end
            S_OFS2, S_SRT2, S_J4: begin
                alu_req.a = OW'(bst_rd);
                alu_req.b = OW'(1);
            end
            S_ADJ2, S_ADJ3: begin
                alu_req.a   = offs_rd;
                alu_req.b   = OW'(1);
                alu_req.sub = 1'b1;
            end
            S_PFX1: begin
                alu_req.a = r_run;
                alu_req.b = OW'(bst_rd);
            end
            S_J2: begin
                alu_req.a = OW'(deg_rd);
                alu_req.b = OW'(r_dv);
            end
            S_J5: begin
                alu_req.a   = OW'(r_du);
                alu_req.b   = OW'(1);
                alu_req.sub = 1'b1;
            end
            default: ;
        endcase
    end

    // memory port steering
    always_comb begin
        edge_we     = 1'b0;
        edge_waddr  = r_etot[EAW-1:0];
        edge_wdata  = {r_a, r_b};
        edge_raddr  = r_e[EAW-1:0];
        dfull_we    = 1'b0;
        dfull_waddr = r_clr;
        dfull_wdata = '0;
        dfull_raddr = i_cmd.vertex_a;
        deg_we      = 1'b0;
        deg_waddr   = r_clr;
        deg_wdata   = '0;
        deg_raddr   = i_cmd.vertex_a;
        offs_we     = 1'b0;
        offs_waddr  = r_v;
        offs_wdata  = alu_rsp.sum;
        offs_raddr  = {1'b0, e_a};
        adj_we      = 1'b0;
        adj_waddr   = alu_rsp.sum[AAW-1:0];
        adj_wdata   = r_eb;
        adj_raddr   = r_j[AAW-1:0];
        bst_we      = 1'b0;
        bst_waddr   = r_clr;
        bst_wdata   = '0;
        bst_raddr   = r_d;
        pos_we      = 1'b0;
        pos_waddr   = r_v[VW-1:0];
        pos_wdata   = bst_rd[VW-1:0];
        pos_raddr   = r_u;
        vert_we     = 1'b0;
        vert_waddr  = bst_rd[VW-1:0];
        vert_wdata  = r_v[VW-1:0];
        vert_raddr  = r_i[VW-1:0];
        unique case (r_state)
            S_INIT: begin
                dfull_we = 1'b1;
            end
            S_ADD1: begin
                dfull_raddr = r_b;
            end
            S_ADD2: begin
                if (!(r_da >= gcd_pkg::MAX_DEGREE || dfull_rd >= gcd_pkg::MAX_DEGREE)) begin
                    dfull_we    = 1'b1;
                    dfull_waddr = r_b;
                    dfull_wdata = alu_rsp.sum[VW-1:0];
                    edge_we     = 1'b1;
                end
            end
            S_ADD3: begin
                dfull_we    = 1'b1;
                dfull_waddr = r_a;
                dfull_wdata = alu_rsp.sum[VW-1:0];
            end
            S_CLR: begin
                deg_we = 1'b1;
                bst_we = 1'b1;
            end
            S_CNT1: begin
                deg_raddr = e_a;
            end
            S_CNT2: begin
                deg_we    = 1'b1;
                deg_waddr = r_ea;
                deg_wdata = alu_rsp.sum[VW-1:0];
                deg_raddr = r_eb;
            end
            S_CNT3: begin
                deg_we    = 1'b1;
                deg_waddr = r_eb;
                deg_wdata = alu_rsp.sum[VW-1:0];
            end
            S_OFS0, S_SRT0: begin
                deg_raddr = r_v[VW-1:0];
            end
            S_OFS1: begin
                offs_we   = 1'b1;
                bst_raddr = deg_rd;
            end
            S_OFS2: begin
                bst_we    = 1'b1;
                bst_waddr = r_dd;
                bst_wdata = alu_rsp.sum[BW-1:0];
            end
            S_OFSN: begin
                offs_we    = 1'b1;
                offs_waddr = n_cnt;
                offs_wdata = r_run;
            end
            S_ADJ2: begin
                offs_we    = 1'b1;
                offs_waddr = {1'b0, r_ea};
                adj_we     = 1'b1;
                offs_raddr = {1'b0, r_eb};
            end
            S_ADJ3: begin
                offs_we    = 1'b1;
                offs_waddr = {1'b0, r_eb};
                adj_we     = 1'b1;
                adj_wdata  = r_ea;
            end
            S_PFX1: begin
                bst_we    = 1'b1;
                bst_waddr = r_d;
                bst_wdata = r_run[BW-1:0];
            end
            S_SRT1: begin
                bst_raddr = deg_rd;
            end
            S_SRT2: begin
                bst_we    = 1'b1;
                bst_waddr = r_dd;
                bst_wdata = alu_rsp.sum[BW-1:0];
                pos_we    = 1'b1;
                vert_we   = 1'b1;
            end
            S_SHF0: begin
                bst_raddr = r_d - VW'(1);
            end
            S_SHF1: begin
                bst_we    = 1'b1;
                bst_waddr = r_d;
                bst_wdata = bst_rd;
            end
            S_SHF2: begin
                bst_we    = 1'b1;
                bst_waddr = '0;
            end
            S_K1: begin
                offs_raddr = {1'b0, vert_rd};
            end
            S_K2: begin
                offs_raddr = r_v + CW'(1);
            end
            S_K3: begin
                deg_raddr = r_v[VW-1:0];
            end
            S_J1: begin
                deg_raddr = adj_rd;
            end
            S_J3: begin
                bst_raddr = r_du;
            end
            S_J4: begin
                vert_raddr = bst_rd[VW-1:0];
            end
            S_J5: begin
                deg_we    = 1'b1;
                deg_waddr = r_u;
                deg_wdata = alu_rsp.sum[VW-1:0];
                bst_we    = 1'b1;
                bst_waddr = r_du;
                bst_wdata = r_pw1;
                if (vert_rd != r_u) begin
                    pos_we     = 1'b1;
                    pos_waddr  = r_u;
                    pos_wdata  = r_pw;
                    vert_we    = 1'b1;
                    vert_waddr = r_pu;
                    vert_wdata = vert_rd;
                end
            end
            S_J6: begin
                pos_we     = 1'b1;
                pos_waddr  = r_w;
                pos_wdata  = r_pu;
                vert_we    = 1'b1;
                vert_waddr = r_pw;
                vert_wdata = r_u;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_vcount    <= gcd_pkg::NUM_VERTICES;
            r_etot      <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_out_valid <= 1'b0;
            if (cfg_wr) begin
                r_vcount <= pwdata[CW-1:0];
            end
            unique case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + VW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_a               <= i_cmd.vertex_a;
                        r_b               <= i_cmd.vertex_b;
                        r_res.core_number <= '0;
                        r_res.vertex_id   <= i_cmd.vertex_a;
                        r_res.status      <= gcd_pkg::ST_OK;
                        case (i_cmd.opcode)
                            gcd_pkg::OP_ADD: begin
                                if ({1'b0, i_cmd.vertex_a} >= n_cnt ||
                                    {1'b0, i_cmd.vertex_b} >= n_cnt ||
                                    i_cmd.vertex_a == i_cmd.vertex_b) begin
                                    r_res.status <= gcd_pkg::ST_BAD;
                                    r_out_valid  <= 1'b1;
                                end else if (r_etot >= gcd_pkg::NUM_EDGES) begin
                                    r_res.status <= gcd_pkg::ST_FULL;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_ADD1;
                                end
                            end
                            gcd_pkg::OP_RUN: begin
                                r_clr   <= '0;
                                r_md    <= '0;
                                r_state <= S_CLR;
                            end
                            gcd_pkg::OP_READ: begin
                                if (!r_rv) begin
                                    r_res.status <= gcd_pkg::ST_INVALID;
                                    r_out_valid  <= 1'b1;
                                end else if ({1'b0, i_cmd.vertex_a} >= n_cnt) begin
                                    r_res.status <= gcd_pkg::ST_BAD;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ADD1: begin
                    r_da    <= dfull_rd;
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    if (r_da >= gcd_pkg::MAX_DEGREE || dfull_rd >= gcd_pkg::MAX_DEGREE) begin
                        r_res.status <= gcd_pkg::ST_FULL;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_etot  <= r_etot + EW'(1);
                        r_rv    <= 1'b0;
                        r_state <= S_ADD3;
                    end
                end
                S_ADD3: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_READ: begin
                    r_res.core_number <= deg_rd;
                    r_out_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                // clear degrees and buckets
                S_CLR: begin
                    r_clr <= r_clr + VW'(1);
                    if (r_clr == '1) begin
                        r_e     <= '0;
                        r_state <= S_CNT0;
                    end
                end
                // degree count over in-range edges
                S_CNT0: begin
                    if (r_e == r_etot) begin
                        r_v     <= '0;
                        r_run   <= '0;
                        r_state <= S_OFS0;
                    end else begin
                        r_state <= S_CNT1;
                    end
                end
                S_CNT1: begin
                    r_ea <= e_a;
                    r_eb <= e_b;
                    if (e_in) begin
                        r_state <= S_CNT2;
                    end else begin
                        r_e     <= r_e + EW'(1);
                        r_state <= S_CNT0;
                    end
                end
                S_CNT2: begin
                    if (alu_rsp.sum[VW-1:0] > r_md) begin
                        r_md <= alu_rsp.sum[VW-1:0];
                    end
                    r_state <= S_CNT3;
                end
                S_CNT3: begin
                    if (alu_rsp.sum[VW-1:0] > r_md) begin
                        r_md <= alu_rsp.sum[VW-1:0];
                    end
                    r_e     <= r_e + EW'(1);
                    r_state <= S_CNT0;
                end
                // adjacency offsets and bucket counts
                S_OFS0: begin
                    r_state <= S_OFS1;
                end
                S_OFS1: begin
                    r_run   <= alu_rsp.sum;
                    r_dd    <= deg_rd;
                    r_state <= S_OFS2;
                end
                S_OFS2: begin
                    r_v <= r_v + CW'(1);
                    if (r_v + CW'(1) == n_cnt) begin
                        r_state <= S_OFSN;
                    end else begin
                        r_state <= S_OFS0;
                    end
                end
                S_OFSN: begin
                    r_e     <= '0;
                    r_state <= S_ADJ0;
                end
                // adjacency fill
                S_ADJ0: begin
                    if (r_e == r_etot) begin
                        r_d     <= '0;
                        r_run   <= '0;
                        r_state <= S_PFX0;
                    end else begin
                        r_state <= S_ADJ1;
                    end
                end
                S_ADJ1: begin
                    r_ea <= e_a;
                    r_eb <= e_b;
                    if (e_in) begin
                        r_state <= S_ADJ2;
                    end else begin
                        r_e     <= r_e + EW'(1);
                        r_state <= S_ADJ0;
                    end
                end
                S_ADJ2: begin
                    r_state <= S_ADJ3;
                end
                S_ADJ3: begin
                    r_e     <= r_e + EW'(1);
                    r_state <= S_ADJ0;
                end
                // bucket counts to bucket starts
                S_PFX0: begin
                    r_state <= S_PFX1;
                end
                S_PFX1: begin
                    r_run <= alu_rsp.sum;
                    r_d   <= r_d + VW'(1);
                    if (r_d == r_md) begin
                        r_v     <= '0;
                        r_state <= S_SRT0;
                    end else begin
                        r_state <= S_PFX0;
                    end
                end
                // place vertices in degree order
                S_SRT0: begin
                    r_state <= S_SRT1;
                end
                S_SRT1: begin
                    r_dd    <= deg_rd;
                    r_state <= S_SRT2;
                end
                S_SRT2: begin
                    r_v <= r_v + CW'(1);
                    if (r_v + CW'(1) == n_cnt) begin
                        r_d <= r_md;
                        if (r_md == '0) begin
                            r_state <= S_SHF2;
                        end else begin
                            r_state <= S_SHF0;
                        end
                    end else begin
                        r_state <= S_SRT0;
                    end
                end
                // bucket starts back down by one slot
                S_SHF0: begin
                    r_state <= S_SHF1;
                end
                S_SHF1: begin
                    r_d <= r_d - VW'(1);
                    if (r_d == VW'(1)) begin
                        r_state <= S_SHF2;
                    end else begin
                        r_state <= S_SHF0;
                    end
                end
                S_SHF2: begin
                    r_i     <= '0;
                    r_state <= S_K0;
                end
                // peel: per vertex
                S_K0: begin
                    r_state <= S_K1;
                end
                S_K1: begin
                    r_v     <= {1'b0, vert_rd};
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_j     <= offs_rd;
                    r_state <= S_K3;
                end
                S_K3: begin
                    r_jend  <= offs_rd;
                    r_state <= S_K4;
                end
                S_K4: begin
                    r_dv    <= deg_rd;
                    r_state <= S_J0;
                end
                // peel: per neighbour
                S_J0: begin
                    if (r_j == r_jend) begin
                        r_i <= r_i + CW'(1);
                        if (r_i + CW'(1) == n_cnt) begin
                            r_rv        <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_K0;
                        end
                    end else begin
                        r_state <= S_J1;
                    end
                end
                S_J1: begin
                    r_u     <= adj_rd;
                    r_state <= S_J2;
                end
                S_J2: begin
                    r_du <= deg_rd;
                    if (alu_rsp.gt) begin
                        r_state <= S_J3;
                    end else begin
                        r_j     <= r_j + OW'(1);
                        r_state <= S_J0;
                    end
                end
                S_J3: begin
                    r_pu    <= pos_rd;
                    r_state <= S_J4;
                end
                S_J4: begin
                    r_pw    <= bst_rd[VW-1:0];
                    r_pw1   <= alu_rsp.sum[BW-1:0];
                    r_state <= S_J5;
                end
                S_J5: begin
                    r_w <= vert_rd;
                    if (vert_rd != r_u) begin
                        r_state <= S_J6;
                    end else begin
                        r_j     <= r_j + OW'(1);
                        r_state <= S_J0;
                    end
                end
                S_J6: begin
                    r_j     <= r_j + OW'(1);
                    r_state <= S_J0;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;
    assign prdata  = {21'd0, r_vcount};
    assign pready  = 1'b1;

endmodule

>>> rtl/core/gcd_ram.sv
// ----------------------------------------------------------------------------
// gcd_ram: simple dual-port work memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gcd_ram #(
    parameter int unsigned W = 10,
    parameter int unsigned D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/gcd_alu.sv
// ----------------------------------------------------------------------------
// gcd_alu: shared add/subtract/compare unit
// Serves every count, prefix sum and degree update of the sequencer.
// ----------------------------------------------------------------------------
module gcd_alu (
    input  gcd_pkg::t_alu_req i_req,
    output gcd_pkg::t_alu_rsp o_rsp
);

    always_comb begin
        o_rsp.sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
        o_rsp.gt  = (i_req.a > i_req.b);
    end

endmodule

>>> rtl/core/gcd_chk.sv
// ----------------------------------------------------------------------------
// gcd_chk: port-level checks for the k-core decomposition block
// Result, busy and vertex count readback behaviour; bound to the top level.
// ----------------------------------------------------------------------------
module gcd_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input gcd_pkg::t_cmd i_cmd,
    input logic          o_valid,
    input gcd_pkg::t_res o_res,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    // only an ok read carries a core number
    a_core_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.core_number != '0 |-> o_res.status == gcd_pkg::ST_OK)
        else $error("core number on a non-ok result");

    // an accepted run transaction makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.opcode == gcd_pkg::OP_RUN |=> busy)
        else $error("run did not make the block busy");

    // a result follows an accepted transaction or ongoing work
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy) || $past(busy))
        else $error("result with no transaction behind it");

    // a written vertex count reads back
    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] == 1'b0
        |=> prdata[10:0] == $past(pwdata[10:0]) && prdata[31:11] == '0)
        else $error("vertex count readback mismatch");

endmodule

bind graph_core_decomposition gcd_chk u_gcd_chk (.*);
